// ----- rtl/gsm_pkg.sv -----
// gsm_pkg: shared types, codes and constants of the golden section minimiser
// used by every module under rtl; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package gsm_pkg;

   localparam logic       OP_START = 1'b0;
   localparam logic       OP_VALUE = 1'b1;

   localparam logic [1:0] STATUS_EVAL       = 2'd0;
   localparam logic [1:0] STATUS_CONVERGED  = 2'd1;
   localparam logic [1:0] STATUS_LIMIT      = 2'd2;
   localparam logic [1:0] STATUS_NOT_ACTIVE = 2'd3;

   // 1 - 0.61803399 as unsigned Q0.32
   localparam logic [31:0] GOLDEN_C = 32'd1640531521;
   localparam logic [63:0] ROUND_HALF = 64'h0000_0000_8000_0000;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic        CSR_IDX_TOLERANCE = 1'b0;
   localparam logic        CSR_IDX_MAX_ITER  = 1'b1;

   localparam logic [15:0] TOLERANCE_RESET = 16'd66;
   localparam logic [15:0] MAX_ITER_RESET  = 16'd100;

   typedef struct packed {
      logic [15:0] tolerance;
      logic [15:0] max_iter;
   } cfg_type;

   typedef struct packed {
      logic        op;
      logic [31:0] left_point;
      logic [31:0] mid_point;
      logic [31:0] right_point;
      logic [31:0] mid_value;
      logic [31:0] func_value;
   } item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] point;
      logic [31:0] value;
      logic [16:0] iterations;
   } result_type;

   // magnitude of an exact 33-bit difference of two Q16.16 values
   function automatic logic [31:0] mag_of(input logic [32:0] d);
      logic [32:0] m;
      m = d[32] ? (~d + 33'd1) : d;
      return m[31:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/gsm_csr.sv -----
// gsm_csr: tolerance and iteration limit registers behind the apb-style port
// depends on gsm_pkg
`timescale 1ns / 1ps
`default_nettype none

module gsm_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [gsm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [31:0]                      pwdata,
   output logic      [31:0]                      prdata,
   output logic                                  pready,
   output gsm_pkg::cfg_type                      cfg
);

   gsm_pkg::cfg_type cfg_ff, cfg_in;
   logic             reg_idx;
   logic             wr_en;

   assign reg_idx = paddr[2];
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            gsm_pkg::CSR_IDX_TOLERANCE: cfg_in.tolerance = pwdata[15:0];
            gsm_pkg::CSR_IDX_MAX_ITER:  cfg_in.max_iter  = pwdata[15:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tolerance <= gsm_pkg::TOLERANCE_RESET;
         cfg_ff.max_iter  <= gsm_pkg::MAX_ITER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         gsm_pkg::CSR_IDX_TOLERANCE: prdata = {16'd0, cfg_ff.tolerance};
         gsm_pkg::CSR_IDX_MAX_ITER:  prdata = {16'd0, cfg_ff.max_iter};
         default:                    prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/gsm_probe.sv -----
// gsm_probe: next probe p + round(C * (q - p)) in Q16.16, one 32x32 multiply
// depends on gsm_pkg
`timescale 1ns / 1ps
`default_nettype none

module gsm_probe (
   input  wire logic [31:0] p,
   input  wire logic [31:0] q,
   output logic      [31:0] probe
);

   logic [32:0] diff;
   logic [31:0] mag;
   logic [63:0] prod;
   logic [63:0] rounded;
   logic [32:0] sum;

   assign diff    = {q[31], q} - {p[31], p};
   assign mag     = gsm_pkg::mag_of(diff);
   assign prod    = {32'd0, mag} * {32'd0, gsm_pkg::GOLDEN_C};
   assign rounded = prod + gsm_pkg::ROUND_HALF;
   // halves away from zero: round the magnitude, then apply the sign
   assign sum     = diff[32] ? ({p[31], p} - {1'b0, rounded[63:32]})
                             : ({p[31], p} + {1'b0, rounded[63:32]});
   assign probe   = sum[31:0];

endmodule

`default_nettype wire

// ----- rtl/gsm_core.sv -----
// gsm_core: search state and the per-item update, result formed combinationally
// depends on gsm_pkg and gsm_probe
`timescale 1ns / 1ps
`default_nettype none

module gsm_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire gsm_pkg::item_type    item,
   input  wire gsm_pkg::cfg_type     cfg,
   output gsm_pkg::result_type       result
);

   logic [31:0] outer_low_ff,  outer_low_in;
   logic [31:0] inner_low_ff,  inner_low_in;
   logic [31:0] inner_high_ff, inner_high_in;
   logic [31:0] outer_high_ff, outer_high_in;
   logic [31:0] value_low_ff,  value_low_in;
   logic [31:0] value_high_ff, value_high_in;
   logic [16:0] count_ff,      count_in;
   logic        awaiting_low_ff, awaiting_low_in;
   logic        active_ff,       active_in;

   logic [32:0] diff_right, diff_left;
   logic        wide_right;
   logic [31:0] vl_new, vh_new;
   logic [32:0] span;
   logic [47:0] width;
   logic [32:0] mag_sum;
   logic [48:0] scale;
   logic        go;
   logic        keep_high;
   logic [31:0] probe_p, probe_q, probe;
   logic [16:0] count_next;

   assign diff_right = {item.right_point[31], item.right_point}
                     - {item.mid_point[31], item.mid_point};
   assign diff_left  = {item.mid_point[31], item.mid_point}
                     - {item.left_point[31], item.left_point};
   assign wide_right = gsm_pkg::mag_of(diff_right) > gsm_pkg::mag_of(diff_left);

   assign vl_new = awaiting_low_ff ? item.func_value : value_low_ff;
   assign vh_new = awaiting_low_ff ? value_high_ff : item.func_value;

   // stop rule on the stored bracket, exact
   assign span    = {outer_high_ff[31], outer_high_ff} - {outer_low_ff[31], outer_low_ff};
   assign width   = {gsm_pkg::mag_of(span), 16'd0};
   assign mag_sum = {1'b0, gsm_pkg::mag_of({inner_low_ff[31], inner_low_ff})}
                  + {1'b0, gsm_pkg::mag_of({inner_high_ff[31], inner_high_ff})};
   assign scale   = {33'd0, cfg.tolerance} * {16'd0, mag_sum};
   assign go      = ({1'b0, width} > scale) && (count_ff <= {1'b0, cfg.max_iter});

   assign keep_high  = $signed(vh_new) < $signed(vl_new);
   assign count_next = count_ff + 17'd1;

   always_comb begin
      if (item.op == gsm_pkg::OP_START) begin
         probe_p = item.mid_point;
         probe_q = wide_right ? item.right_point : item.left_point;
      end else begin
         probe_p = keep_high ? inner_high_ff : inner_low_ff;
         probe_q = keep_high ? outer_high_ff : outer_low_ff;
      end
   end

   gsm_probe u_probe (
      .p     (probe_p),
      .q     (probe_q),
      .probe (probe)
   );

   always_comb begin
      outer_low_in    = outer_low_ff;
      inner_low_in    = inner_low_ff;
      inner_high_in   = inner_high_ff;
      outer_high_in   = outer_high_ff;
      value_low_in    = value_low_ff;
      value_high_in   = value_high_ff;
      count_in        = count_ff;
      awaiting_low_in = awaiting_low_ff;
      active_in       = active_ff;
      result          = '0;

      priority if (item.op == gsm_pkg::OP_START) begin
         outer_low_in  = item.left_point;
         outer_high_in = item.right_point;
         if (wide_right) begin
            inner_low_in    = item.mid_point;
            value_low_in    = item.mid_value;
            inner_high_in   = probe;
            value_high_in   = 32'd0;
            awaiting_low_in = 1'b0;
         end else begin
            inner_high_in   = item.mid_point;
            value_high_in   = item.mid_value;
            inner_low_in    = probe;
            value_low_in    = 32'd0;
            awaiting_low_in = 1'b1;
         end
         count_in      = 17'd0;
         active_in     = 1'b1;
         result.status = gsm_pkg::STATUS_EVAL;
         result.point  = probe;
      end else if (!active_ff) begin
         result.status = gsm_pkg::STATUS_NOT_ACTIVE;
      end else if (go) begin
         if (keep_high) begin
            outer_low_in    = inner_low_ff;
            inner_low_in    = inner_high_ff;
            value_low_in    = vh_new;
            value_high_in   = vh_new;
            inner_high_in   = probe;
            awaiting_low_in = 1'b0;
         end else begin
            outer_high_in   = inner_high_ff;
            inner_high_in   = inner_low_ff;
            value_high_in   = vl_new;
            value_low_in    = vl_new;
            inner_low_in    = probe;
            awaiting_low_in = 1'b1;
         end
         count_in          = count_next;
         result.status     = gsm_pkg::STATUS_EVAL;
         result.point      = probe;
         result.iterations = count_next;
      end else begin
         value_low_in  = vl_new;
         value_high_in = vh_new;
         active_in     = 1'b0;
         result.status = (count_ff > {1'b0, cfg.max_iter}) ? gsm_pkg::STATUS_LIMIT
                                                           : gsm_pkg::STATUS_CONVERGED;
         if ($signed(vl_new) < $signed(vh_new)) begin
            result.point = inner_low_ff;
            result.value = vl_new;
         end else begin
            result.point = inner_high_ff;
            result.value = vh_new;
         end
         result.iterations = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff       <= 1'b0;
         awaiting_low_ff <= 1'b0;
      end else if (step) begin
         active_ff       <= active_in;
         awaiting_low_ff <= awaiting_low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         outer_low_ff  <= outer_low_in;
         inner_low_ff  <= inner_low_in;
         inner_high_ff <= inner_high_in;
         outer_high_ff <= outer_high_in;
         value_low_ff  <= value_low_in;
         value_high_ff <= value_high_in;
         count_ff      <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/golden_section_minimizer.sv -----
// golden_section_minimizer: top level with input and result registers
// depends on gsm_pkg, gsm_csr and gsm_core
//
// Usage
//   req channel: op 0 starts a search with a bracket (left, mid, right) and the
//   value at mid; op 1 returns the function value at the last requested point.
//   rsp channel: exactly one item per request item. status 0 asks the partner
//   to evaluate rsp_point; 1 and 2 report the minimum (converged or iteration
//   limit) with its value and iteration count; 3 answers a value while idle.
//   An item is taken on an edge with valid high and stall low.
//   The result of a taken item is registered in the result register.
//   Throughput: one item per cycle while the result is not stalled; the state update,
//   probe multiply and tolerance multiply all sit between the input and result registers.
//   In practice the partner's evaluation sets the pace, as every request
//   waits for its own result.
//   Stall: a stalled result holds; one more item is held in the input
//   register, after which req_stall rises until the result is taken.
//   Reset: no search active, both registers empty, tolerance 66, limit 100.
//   The apb-style port at byte address 0 (tolerance) and 4 (limit) is to be written by the
//   user only while no item is in flight; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module golden_section_minimizer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_op,
   input  wire logic signed [31:0]             req_left_point,
   input  wire logic signed [31:0]             req_mid_point,
   input  wire logic signed [31:0]             req_right_point,
   input  wire logic signed [31:0]             req_mid_value,
   input  wire logic signed [31:0]             req_func_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [1:0]                     rsp_status,
   output logic signed [31:0]                  rsp_point,
   output logic signed [31:0]                  rsp_value,
   output logic      [16:0]                    rsp_iterations,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [gsm_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                    pwdata,
   output logic      [31:0]                    prdata,
   output logic                                pready
);

   gsm_pkg::cfg_type    cfg;
   gsm_pkg::item_type   item_ff, item_in;
   gsm_pkg::result_type result, result_ff;
   logic                in_valid_ff;
   logic                out_valid_ff;
   logic                out_adv;
   logic                in_adv;
   logic                step;

   assign out_adv   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_adv;
   assign in_adv    = !in_valid_ff || out_adv;
   assign req_stall = !in_adv;

   assign item_in.op          = req_op;
   assign item_in.left_point  = req_left_point;
   assign item_in.mid_point   = req_mid_point;
   assign item_in.right_point = req_right_point;
   assign item_in.mid_value   = req_mid_value;
   assign item_in.func_value  = req_func_value;

   gsm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gsm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_adv) begin
            in_valid_ff <= req_valid;
         end
         if (out_adv) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv && req_valid) begin
         item_ff <= item_in;
      end
      if (step) begin
         result_ff <= result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = result_ff.status;
   assign rsp_point      = result_ff.point;
   assign rsp_value      = result_ff.value;
   assign rsp_iterations = result_ff.iterations;

endmodule

`default_nettype wire

// ----- rtl/gsm_checker.sv -----
// gsm_checker: port-level checks on the result channel of the minimiser
// depends on gsm_pkg; bound to golden_section_minimizer
`timescale 1ns / 1ps
`default_nettype none

module gsm_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [1:0]                     rsp_status,
   input wire logic [31:0]                    rsp_point,
   input wire logic [31:0]                    rsp_value,
   input wire logic [16:0]                    rsp_iterations
);

   // nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item shown straight after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
                                && $stable(rsp_point) && $stable(rsp_iterations))
      else $error("stalled result item changed");

   a_eval_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == gsm_pkg::STATUS_EVAL |-> rsp_value == 32'd0)
      else $error("evaluate request carries a value");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == gsm_pkg::STATUS_NOT_ACTIVE
         |-> rsp_point == 32'd0 && rsp_value == 32'd0 && rsp_iterations == 17'd0)
      else $error("not-active answer carries data");

   // the limit is only reached past at least one iteration
   a_limit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == gsm_pkg::STATUS_LIMIT |-> rsp_iterations != 17'd0)
      else $error("iteration limit with zero iterations");

endmodule

bind golden_section_minimizer gsm_checker u_gsm_checker (.*);

`default_nettype wire

// ----- verif/golden_section_minimizer_tb.sv -----
// golden_section_minimizer_tb: self-checking testbench for the golden section minimiser,
// a directed script then randomised searches against an in-bench predictor
// depends on gsm_pkg and golden_section_minimizer under rtl
`timescale 1ns / 1ps

module golden_section_minimizer_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS = 160;
   localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic                csr_index;
      logic [15:0]         csr_data;
      gsm_pkg::item_type   req;
      logic                typed;
      gsm_pkg::result_type rsp;
   } script_row_type;

   localparam gsm_pkg::item_type   NO_ITEM  = '0;
   localparam gsm_pkg::result_type NO_RSP   = '0;
   localparam gsm_pkg::result_type IDLE_RSP =
      '{gsm_pkg::STATUS_NOT_ACTIVE, 32'd0, 32'd0, 17'd0};

   localparam script_row_type SCRIPT [24] = '{
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_VALUE, 32'd0, 32'd0, 32'd0, 32'd0, Q_MAX}, 1'b1, IDLE_RSP},
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_VALUE, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN}, 1'b1, IDLE_RSP},
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_START, 32'd0, 32'd0, 32'd0, 32'h0007_0000, 32'd0},
        1'b1, '{gsm_pkg::STATUS_EVAL, 32'd0, 32'd0, 17'd0}},
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_VALUE, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0005_0000},
        1'b1, '{gsm_pkg::STATUS_CONVERGED, 32'd0, 32'h0005_0000, 17'd0}},
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_START, Q_MIN, 32'd0, Q_MAX, Q_MIN, Q_MAX}, 1'b0, NO_RSP},
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_VALUE, 32'd0, 32'd0, 32'd0, 32'd0, Q_MAX}, 1'b0, NO_RSP},
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_VALUE, 32'd0, 32'd0, 32'd0, 32'd0, Q_MIN}, 1'b0, NO_RSP},
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_VALUE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b0, NO_RSP},
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_START, 32'h0064_0000, 32'h0032_0000, 32'hFF38_0000, 32'h0001_0000,
          32'd0},
        1'b0, NO_RSP},
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_VALUE, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0001_0000},
        1'b0, NO_RSP},
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_VALUE, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0001_0000},
        1'b0, NO_RSP},
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_START, 32'hFFFF_0000, 32'd0, 32'h0001_0000, Q_MAX, 32'd0},
        1'b0, NO_RSP},
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_VALUE, 32'd0, 32'd0, 32'd0, 32'd0, Q_MAX}, 1'b0, NO_RSP},
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_START, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN}, 1'b0, NO_RSP},
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_VALUE, 32'd0, 32'd0, 32'd0, 32'd0, Q_MIN}, 1'b0, NO_RSP},
      '{ROW_CSR, gsm_pkg::CSR_IDX_MAX_ITER, 16'd0, NO_ITEM, 1'b0, NO_RSP},
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_START, 32'd0, 32'h0001_0000, 32'h0003_0000, 32'h0001_0000, 32'd0},
        1'b0, NO_RSP},
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_VALUE, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0002_0000},
        1'b0, NO_RSP},
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_VALUE, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0002_0000},
        1'b0, NO_RSP},
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_VALUE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1, IDLE_RSP},
      '{ROW_CSR, gsm_pkg::CSR_IDX_TOLERANCE, 16'hFFFF, NO_ITEM, 1'b0, NO_RSP},
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_START, 32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 32'd0, 32'd0},
        1'b0, NO_RSP},
      '{ROW_ITEM, 1'b0, 16'd0,
        '{gsm_pkg::OP_VALUE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1}, 1'b0, NO_RSP},
      '{ROW_CSR, gsm_pkg::CSR_IDX_TOLERANCE, 16'd0, NO_ITEM, 1'b0, NO_RSP}
   };

   localparam logic [15:0] PHASE_TOL   [6] = '{16'd66, 16'd0, 16'hFFFF, 16'd1000, 16'd0, 16'd300};
   localparam logic [15:0] PHASE_LIMIT [6] = '{16'd100, 16'd3, 16'hFFFF, 16'd0, 16'hFFFF, 16'd20};
   localparam int SEND_IDLE [3] = '{22, 73, 0};
   localparam int RECV_IDLE [3] = '{73, 22, 0};

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_op = gsm_pkg::OP_START;
   logic signed [31:0]            req_left_point = '0;
   logic signed [31:0]            req_mid_point = '0;
   logic signed [31:0]            req_right_point = '0;
   logic signed [31:0]            req_mid_value = '0;
   logic signed [31:0]            req_func_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [1:0]                    rsp_status;
   logic signed [31:0]            rsp_point;
   logic signed [31:0]            rsp_value;
   logic [16:0]                   rsp_iterations;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [gsm_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]                   pwdata = '0;
   logic [31:0]                   prdata;
   logic                          pready;

   // predictor copy of the search state and registers
   logic signed [31:0] br_outer_lo = '0, br_inner_lo = '0, br_inner_hi = '0, br_outer_hi = '0;
   logic signed [31:0] f_inner_lo = '0, f_inner_hi = '0;
   logic [16:0]        iter_done = '0;
   logic               want_low = 1'b0;
   logic               searching = 1'b0;
   logic [15:0]        cfg_tolerance = gsm_pkg::TOLERANCE_RESET;
   logic [15:0]        cfg_max_iter = gsm_pkg::MAX_ITER_RESET;

   gsm_pkg::result_type due_replies [$];
   logic                row_typed = 1'b0;
   gsm_pkg::result_type row_expect = '0;
   int                  error_count = 0;
   int                  quiet_cycles = 0;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;

   // objective the bench evaluates on behalf of the block
   logic signed [31:0] obj_center = '0;
   logic signed [31:0] obj_floor = '0;
   int                 obj_shift = 0;
   int                 probes_left = 0;

   golden_section_minimizer i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   function automatic longint unsigned magnitude(input longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic logic signed [31:0] golden_probe(input logic signed [31:0] keep,
                                                       input logic signed [31:0] far);
      longint            span;
      longint unsigned   step;
      span = longint'(far) - longint'(keep);
      step = (magnitude(span) * longint'(gsm_pkg::GOLDEN_C) + 64'h8000_0000) >> 32;
      return (span < 0) ? 32'(longint'(keep) - longint'(step))
                        : 32'(longint'(keep) + longint'(step));
   endfunction

   function automatic gsm_pkg::result_type search_step(input gsm_pkg::item_type it);
      logic signed [31:0]  lo_end, mid, hi_end;
      longint unsigned     width, scale;
      gsm_pkg::result_type res;
      res = '0;
      if (it.op == gsm_pkg::OP_START) begin
         lo_end = it.left_point;
         mid = it.mid_point;
         hi_end = it.right_point;
         br_outer_lo = lo_end;
         br_outer_hi = hi_end;
         if (magnitude(longint'(hi_end) - longint'(mid)) >
             magnitude(longint'(mid) - longint'(lo_end))) begin
            br_inner_lo = mid;
            f_inner_lo = it.mid_value;
            br_inner_hi = golden_probe(mid, hi_end);
            f_inner_hi = '0;
            want_low = 1'b0;
         end else begin
            br_inner_hi = mid;
            f_inner_hi = it.mid_value;
            br_inner_lo = golden_probe(mid, lo_end);
            f_inner_lo = '0;
            want_low = 1'b1;
         end
         iter_done = '0;
         searching = 1'b1;
         res.status = gsm_pkg::STATUS_EVAL;
         res.point = want_low ? br_inner_lo : br_inner_hi;
         return res;
      end
      if (!searching) begin
         res.status = gsm_pkg::STATUS_NOT_ACTIVE;
         return res;
      end
      if (want_low) f_inner_lo = it.func_value;
      else f_inner_hi = it.func_value;
      width = magnitude(longint'(br_outer_hi) - longint'(br_outer_lo)) << 16;
      scale = longint'(cfg_tolerance) *
              (magnitude(longint'(br_inner_lo)) + magnitude(longint'(br_inner_hi)));
      if (width > scale && iter_done <= 17'(cfg_max_iter)) begin
         if (f_inner_hi < f_inner_lo) begin
            br_outer_lo = br_inner_lo;
            br_inner_lo = br_inner_hi;
            f_inner_lo = f_inner_hi;
            br_inner_hi = golden_probe(br_inner_lo, br_outer_hi);
            want_low = 1'b0;
         end else begin
            br_outer_hi = br_inner_hi;
            br_inner_hi = br_inner_lo;
            f_inner_hi = f_inner_lo;
            br_inner_lo = golden_probe(br_inner_hi, br_outer_lo);
            want_low = 1'b1;
         end
         iter_done = iter_done + 17'd1;
         res.status = gsm_pkg::STATUS_EVAL;
         res.point = want_low ? br_inner_lo : br_inner_hi;
         res.iterations = iter_done;
         return res;
      end
      searching = 1'b0;
      res.status = (iter_done > 17'(cfg_max_iter)) ? gsm_pkg::STATUS_LIMIT
                                                   : gsm_pkg::STATUS_CONVERGED;
      if (f_inner_lo < f_inner_hi) begin
         res.point = br_inner_lo;
         res.value = f_inner_lo;
      end else begin
         res.point = br_inner_hi;
         res.value = f_inner_hi;
      end
      res.iterations = iter_done;
      return res;
   endfunction

   // v-shaped cost around obj_center, saturated to the q16.16 range
   function automatic logic signed [31:0] cost_at(input logic signed [31:0] x);
      longint gap;
      gap = longint'(x) - longint'(obj_center);
      if (gap < 0) gap = -gap;
      gap = (gap >>> obj_shift) + longint'(obj_floor);
      if (gap > 64'sh7FFF_FFFF) gap = 64'sh7FFF_FFFF;
      return gap[31:0];
   endfunction

   always @(posedge clock) begin
      gsm_pkg::result_type seen;
      gsm_pkg::result_type due;
      gsm_pkg::item_type   taken;
      logic                busy;
      busy = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            busy = 1'b1;
            seen = '{rsp_status, rsp_point, rsp_value, rsp_iterations};
            if (due_replies.size() == 0) begin
               $error("unexpected item: status %0d point %h", seen.status, seen.point);
               error_count++;
            end else begin
               due = due_replies.pop_front();
               if (seen.status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, seen.status);
                  error_count++;
               end
               if (seen.point !== due.point) begin
                  $error("point: expected %h, got %h", due.point, seen.point);
                  error_count++;
               end
               if (seen.value !== due.value) begin
                  $error("value: expected %h, got %h", due.value, seen.value);
                  error_count++;
               end
               if (seen.iterations !== due.iterations) begin
                  $error("iterations: expected %0d, got %0d", due.iterations, seen.iterations);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            busy = 1'b1;
            taken = '{req_op, req_left_point, req_mid_point, req_right_point,
                      req_mid_value, req_func_value};
            due = search_step(taken);
            due_replies.push_back(row_typed ? row_expect : due);
         end
         if (psel && penable && pready) busy = 1'b1;
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clock);
      $display("golden_section_minimizer_tb: done, errors");
      $finish;
   end

   task automatic sender_gap();
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic offer_item(input gsm_pkg::item_type it, input logic known,
                             input gsm_pkg::result_type answer);
      row_typed = known;
      row_expect = answer;
      req_op <= it.op;
      req_left_point <= it.left_point;
      req_mid_point <= it.mid_point;
      req_right_point <= it.right_point;
      req_mid_value <= it.mid_value;
      req_func_value <= it.func_value;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_replies.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic index, input logic [15:0] data);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= 32'(data);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (index == gsm_pkg::CSR_IDX_TOLERANCE) cfg_tolerance = data;
      else cfg_max_iter = data;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      // read back
      @(negedge clock);
      psel <= 1'b1;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== 32'(data)) begin
         $error("register %0d: expected %h, got %h", index, data, prdata);
         error_count++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic next_random_item(output gsm_pkg::item_type it);
      int                 pick;
      int                 shape;
      logic [31:0]        half_lo, half_hi;
      logic signed [31:0] mid, probe;
      it.op = gsm_pkg::OP_VALUE;
      it.left_point = $urandom();
      it.mid_point = $urandom();
      it.right_point = $urandom();
      it.mid_value = $urandom();
      it.func_value = $urandom();
      pick = $urandom_range(0, 99);
      if (searching && probes_left > 0 && pick >= 3) begin
         probe = want_low ? br_inner_lo : br_inner_hi;
         probes_left--;
         if (pick >= 16) it.func_value = cost_at(probe);
         else if (pick >= 10) it.func_value = want_low ? f_inner_hi : f_inner_lo;
      end else if (searching || pick >= 10) begin
         it.op = gsm_pkg::OP_START;
         probes_left = $urandom_range(1, 40);
         obj_shift = $urandom_range(0, 4);
         obj_floor = $signed($urandom()) >>> $urandom_range(4, 31);
         shape = $urandom_range(0, 99);
         if (shape < 15) begin
            obj_center = it.mid_point;
         end else begin
            mid = 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            half_lo = $urandom_range(1, 32'h0010_0000);
            half_hi = (shape < 30) ? half_lo : $urandom_range(1, 32'h0010_0000);
            if (shape >= 95) begin
               half_lo = '0;
               half_hi = '0;
            end
            // reversed bracket
            if (shape >= 85 && shape < 95) begin
               it.left_point = mid + half_lo;
               it.right_point = mid - half_hi;
            end else begin
               it.left_point = mid - half_lo;
               it.right_point = mid + half_hi;
            end
            it.mid_point = mid;
            obj_center = mid - half_lo + 32'($urandom_range(0, half_lo + half_hi));
            it.mid_value = cost_at(mid);
         end
      end
   endtask

   initial begin
      gsm_pkg::item_type it;
      int                profile;
      send_idle_pct = SEND_IDLE[0];
      recv_idle_pct = RECV_IDLE[0];
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (SCRIPT[i]) begin
         if (SCRIPT[i].kind == ROW_CSR) begin
            settle();
            write_register(SCRIPT[i].csr_index, SCRIPT[i].csr_data);
         end else begin
            sender_gap();
            offer_item(SCRIPT[i].req, SCRIPT[i].typed, SCRIPT[i].rsp);
         end
      end

      for (int phase = 0; phase < 6; phase++) begin
         settle();
         write_register(gsm_pkg::CSR_IDX_TOLERANCE, PHASE_TOL[phase]);
         write_register(gsm_pkg::CSR_IDX_MAX_ITER, PHASE_LIMIT[phase]);
         profile = phase % 3;
         send_idle_pct = SEND_IDLE[profile];
         recv_idle_pct = RECV_IDLE[profile];
         repeat (PHASE_ITEMS) begin
            sender_gap();
            next_random_item(it);
            offer_item(it, 1'b0, NO_RSP);
         end
      end

      settle();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("golden_section_minimizer_tb: done, clean");
      end else begin
         $display("golden_section_minimizer_tb: done, errors");
      end
      $finish;
   end

endmodule
